[rtl/audio_soft_limiter_assert.svh]
// assertion macros for the audio soft limiter
// used by the top level only; expects a clock i_clk and a low reset i_rst_n in scope
`ifndef AUDIO_SOFT_LIMITER_ASSERT_SVH
`define AUDIO_SOFT_LIMITER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ASL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/asl_pkg.sv]
// shared types and constants of the audio soft limiter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package asl_pkg;

    // fixed field widths
    localparam int LEVEL_W    = 23;
    localparam int KNEE_W     = 47;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 47;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 2'd2;

    // register reset values
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 23'h7F_FFFF;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 23'h7F_FFFF;
    localparam logic [KNEE_W-1:0]  KNEE_RST      = 47'd0;

    // per-word flags carried down the pipeline
    typedef struct packed {
        logic neg;
        logic bypass;
    } t_flags;

endpackage

`default_nettype wire

[rtl/asl_in_if.sv]
// input sample channel of the audio soft limiter
// valid/ready handshake with a signed sample payload; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface asl_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

[rtl/asl_out_if.sv]
// output sample channel of the audio soft limiter
// valid/ready handshake with a signed sample payload; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface asl_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[rtl/asl_prep.sv]
// entry stage: sign, magnitude and threshold test, loads the divider chain
// depends on asl_pkg
`timescale 1ns / 1ps
`default_nettype none

module asl_prep
    import asl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_vld,
    output logic                        o_rdy,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    input  wire logic [LEVEL_W-1:0]     i_thr,
    input  wire logic [KNEE_W-1:0]      i_knee,
    output logic                        o_vld,
    input  wire logic                   i_rdy,
    output logic [SAMPLE_BITS-1:0]      o_raw,
    output t_flags                      o_flg,
    output logic [SAMPLE_BITS-1:0]      o_mag,
    output logic [SAMPLE_BITS-1:0]      o_rem,
    output logic [KNEE_W-1:0]           o_dq
);

    localparam int CW = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    logic                   r_vld;
    logic [SAMPLE_BITS-1:0] r_raw;
    t_flags                 r_flg;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [KNEE_W-1:0]      r_dq;

    logic                   w_load;
    t_flags                 n_flg;
    logic [SAMPLE_BITS-1:0] n_mag;

    // magnitude, most negative sample maps to 2^(n-1) unsigned
    always_comb begin
        n_flg.neg    = i_raw[SAMPLE_BITS-1];
        n_mag        = n_flg.neg ? (~i_raw) + SAMPLE_BITS'(1) : i_raw;
        n_flg.bypass = CW'(n_mag) <= CW'(i_thr);
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign w_load = i_vld && o_rdy;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_raw <= i_raw;
            r_flg <= n_flg;
            r_mag <= n_mag;
            r_dq  <= i_knee;
        end
    end

    assign o_vld = r_vld;
    assign o_raw = r_raw;
    assign o_flg = r_flg;
    assign o_mag = r_mag;
    assign o_rem = '0;
    assign o_dq  = r_dq;

endmodule

`default_nettype wire

[rtl/asl_div_cell.sv]
// one restoring-division cell: takes one dividend bit, yields one quotient bit
// depends on asl_pkg
`timescale 1ns / 1ps
`default_nettype none

module asl_div_cell
    import asl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_vld,
    output logic                        o_rdy,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    input  wire t_flags                 i_flg,
    input  wire logic [SAMPLE_BITS-1:0] i_mag,
    input  wire logic [SAMPLE_BITS-1:0] i_rem,
    input  wire logic [KNEE_W-1:0]      i_dq,
    output logic                        o_vld,
    input  wire logic                   i_rdy,
    output logic [SAMPLE_BITS-1:0]      o_raw,
    output t_flags                      o_flg,
    output logic [SAMPLE_BITS-1:0]      o_mag,
    output logic [SAMPLE_BITS-1:0]      o_rem,
    output logic [KNEE_W-1:0]           o_dq
);

    logic                   r_vld;
    logic [SAMPLE_BITS-1:0] r_raw;
    t_flags                 r_flg;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [KNEE_W-1:0]      r_dq;

    logic                   w_load;
    logic [SAMPLE_BITS:0]   w_part;
    logic [SAMPLE_BITS:0]   w_diff;
    logic                   w_ge;
    logic [SAMPLE_BITS-1:0] n_rem;
    logic [KNEE_W-1:0]      n_dq;

    // shift in the next dividend bit, trial subtract the divisor
    always_comb begin
        w_part = {i_rem, i_dq[KNEE_W-1]};
        w_diff = w_part - {1'b0, i_mag};
        w_ge   = w_part >= {1'b0, i_mag};
        n_rem  = w_ge ? w_diff[SAMPLE_BITS-1:0] : w_part[SAMPLE_BITS-1:0];
        n_dq   = {i_dq[KNEE_W-2:0], w_ge};
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign w_load = i_vld && o_rdy;

    // cell valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_raw <= i_raw;
            r_flg <= i_flg;
            r_mag <= i_mag;
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_vld = r_vld;
    assign o_raw = r_raw;
    assign o_flg = r_flg;
    assign o_mag = r_mag;
    assign o_rem = r_rem;
    assign o_dq  = r_dq;

endmodule

`default_nettype wire

[rtl/asl_post.sv]
// exit stages: round the quotient up, subtract from the peak, clamp and restore sign, or pass a bypassed word raw
// depends on asl_pkg
`timescale 1ns / 1ps
`default_nettype none

module asl_post
    import asl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_vld,
    output logic                        o_rdy,
    input  wire logic [SAMPLE_BITS-1:0] i_raw,
    input  wire t_flags                 i_flg,
    input  wire logic [SAMPLE_BITS-1:0] i_rem,
    input  wire logic [KNEE_W-1:0]      i_quo,
    input  wire logic [LEVEL_W-1:0]     i_max,
    output logic                        o_vld,
    input  wire logic                   i_rdy,
    output logic [SAMPLE_BITS-1:0]      o_data
);

    localparam int PW = (SAMPLE_BITS - 1 > LEVEL_W) ? SAMPLE_BITS - 1 : LEVEL_W;
    localparam logic [PW-1:0] POS_MAX = PW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    logic                   r_a_vld;
    logic [SAMPLE_BITS-1:0] r_a_raw;
    t_flags                 r_a_flg;
    logic [LEVEL_W-1:0]     r_a_lvl;
    logic                   r_b_vld;
    logic [SAMPLE_BITS-1:0] r_b_data;

    logic                   w_a_load;
    logic                   w_b_rdy;
    logic                   w_b_load;
    logic [KNEE_W:0]        w_qc;
    logic                   w_sat;
    logic [LEVEL_W-1:0]     n_a_lvl;
    logic [PW-1:0]          w_ext;
    logic [PW-1:0]          w_clip;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SAMPLE_BITS-1:0] n_b_data;

    // ceiling of the quotient, then peak minus it, saturating at zero
    always_comb begin
        w_qc    = {1'b0, i_quo} + (KNEE_W + 1)'(i_rem != '0);
        w_sat   = w_qc >= (KNEE_W + 1)'(i_max);
        n_a_lvl = w_sat ? '0 : i_max - w_qc[LEVEL_W-1:0];
    end

    // clamp to the positive range of the sample and put the sign back, or pass a bypassed word raw
    always_comb begin
        w_ext  = PW'(r_a_lvl);
        w_clip = (w_ext > POS_MAX) ? POS_MAX : w_ext;
        w_mag  = {1'b0, w_clip[SAMPLE_BITS-2:0]};
        if (r_a_flg.bypass) begin
            n_b_data = r_a_raw;
        end else if (r_a_flg.neg) begin
            n_b_data = (~w_mag) + SAMPLE_BITS'(1);
        end else begin
            n_b_data = w_mag;
        end
    end

    assign w_b_rdy  = !r_b_vld || i_rdy;
    assign o_rdy    = !r_a_vld || w_b_rdy;
    assign w_a_load = i_vld && o_rdy;
    assign w_b_load = r_a_vld && w_b_rdy;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_a_vld <= i_vld;
            end
            if (w_b_rdy) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    // stage payloads, the second one is the output register
    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_raw <= i_raw;
            r_a_flg <= i_flg;
            r_a_lvl <= n_a_lvl;
        end
        if (w_b_load) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_data = r_b_data;

endmodule

`default_nettype wire

[rtl/audio_soft_limiter.sv]
// channel   dir  payload                      handshake
// i_smp     in   sample_in  [SAMPLE_BITS]     valid / ready
// o_smp     out  sample_out [SAMPLE_BITS]     valid / ready
// cfg       in   i_cfg_idx, i_cfg_data [47]   i_cfg_we, no stall
//
// one word per cycle sustained while the output is ready; stages: entry stage, 47 division
// cells (one quotient bit each) and two exit stages
// each stage holds its word until the next one takes it, so bubbles close up
// and input is taken while a finished word waits at the output
// reset is synchronous, active low; it empties the pipeline and restores the registers
// top level of the audio soft limiter; depends on asl_pkg, the channel
// interfaces, asl_prep, asl_div_cell, asl_post and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "audio_soft_limiter_assert.svh"

module audio_soft_limiter
    import asl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    asl_in_if.sink                     i_smp,
    asl_out_if.source                  o_smp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NCELL = KNEE_W;

    logic [LEVEL_W-1:0] r_max;
    logic [LEVEL_W-1:0] r_thr;
    logic [KNEE_W-1:0]  r_knee;

    logic                   w_vld [0:NCELL];
    logic                   w_rdy [0:NCELL];
    logic [SAMPLE_BITS-1:0] w_raw [0:NCELL];
    t_flags                 w_flg [0:NCELL];
    logic [SAMPLE_BITS-1:0] w_mag [0:NCELL];
    logic [SAMPLE_BITS-1:0] w_rem [0:NCELL];
    logic [KNEE_W-1:0]      w_dq  [0:NCELL];
    logic [SAMPLE_BITS-1:0] w_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= MAX_LEVEL_RST;
            r_thr  <= THRESHOLD_RST;
            r_knee <= KNEE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LEVEL: r_max  <= i_cfg_data[LEVEL_W-1:0];
                CFG_THRESHOLD: r_thr  <= i_cfg_data[LEVEL_W-1:0];
                CFG_KNEE:      r_knee <= i_cfg_data[KNEE_W-1:0];
                default: ;
            endcase
        end
    end

    // entry stage
    asl_prep #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_smp.valid),
        .o_rdy   (i_smp.ready),
        .i_raw   (i_smp.sample_in),
        .i_thr   (r_thr),
        .i_knee  (r_knee),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_raw   (w_raw[0]),
        .o_flg   (w_flg[0]),
        .o_mag   (w_mag[0]),
        .o_rem   (w_rem[0]),
        .o_dq    (w_dq[0])
    );

    // chain of division cells, most significant quotient bit first
    for (genvar k = 1; k <= NCELL; k++) begin : g_cell
        asl_div_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k-1]),
            .o_rdy   (w_rdy[k-1]),
            .i_raw   (w_raw[k-1]),
            .i_flg   (w_flg[k-1]),
            .i_mag   (w_mag[k-1]),
            .i_rem   (w_rem[k-1]),
            .i_dq    (w_dq[k-1]),
            .o_vld   (w_vld[k]),
            .i_rdy   (w_rdy[k]),
            .o_raw   (w_raw[k]),
            .o_flg   (w_flg[k]),
            .o_mag   (w_mag[k]),
            .o_rem   (w_rem[k]),
            .o_dq    (w_dq[k])
        );
    end

    // exit stages and output register
    asl_post #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[NCELL]),
        .o_rdy   (w_rdy[NCELL]),
        .i_raw   (w_raw[NCELL]),
        .i_flg   (w_flg[NCELL]),
        .i_rem   (w_rem[NCELL]),
        .i_quo   (w_dq[NCELL]),
        .i_max   (r_max),
        .o_vld   (o_smp.valid),
        .i_rdy   (o_smp.ready),
        .o_data  (w_out)
    );

    assign o_smp.sample_out = w_out;

    // checks on the entry stage and the division chain
    `ASL_ASSERT_NEXT(a_accept_loads, i_smp.valid && i_smp.ready, w_vld[0], "accepted word not in entry stage")
    `ASL_ASSERT_NOW(a_rem_below_div, w_vld[NCELL] && !w_flg[NCELL].bypass, w_rem[NCELL] < w_mag[NCELL], "remainder not below divisor")
    `ASL_ASSERT_NEXT(a_last_cell_holds, w_vld[NCELL] && !w_rdy[NCELL], w_vld[NCELL] && $stable(w_dq[NCELL]), "last cell lost a stalled word")

endmodule

`default_nettype wire
